/* rtl/fasta_nucleotide_packer_assert.svh */
// Assertion macros for the FASTA packer.
`ifndef FASTA_NUCLEOTIDE_PACKER_ASSERT_SVH
`define FASTA_NUCLEOTIDE_PACKER_ASSERT_SVH

// Implication checked outside reset.
`define FNP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define FNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fnp_pkg.sv */
`default_nettype none
package fnp_pkg;

  localparam int CODES_PER_WORD = 8;
  // A word holds at most eight nibbles.
  localparam int WORD_CODES = (CODES_PER_WORD > 8) ? 8 : CODES_PER_WORD;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ASCII_NL = 8'h0A;
  localparam logic [7:0] ASCII_GT = 8'h3E;

  typedef enum logic [1:0] {
    REC_WORD  = 2'd0,
    REC_START = 2'd1,
    REC_END   = 2'd2
  } rec_type_t;

  typedef struct packed {
    rec_type_t   rtype;
    logic [31:0] word;
    logic [3:0]  nvalid;
    logic [15:0] seq_idx;
    logic [31:0] pos;
    logic        last;
  } result_t;

  // Everything one byte produces: one or two results.
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [3:0] base_code(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      8'h41, 8'h61: c = 4'd0;
      8'h43, 8'h63: c = 4'd1;
      8'h47, 8'h67: c = 4'd2;
      8'h54, 8'h74: c = 4'd3;
      default:      c = 4'd4;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/fnp_front.sv */
`default_nettype none
module fnp_front import fnp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_data,
  output logic            q_push,
  output pair_t           q_wdata
);

  logic        header_r, header_nxt;
  logic        lstart_r, lstart_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] bases_r, bases_nxt;
  logic [15:0] seqs_r, seqs_nxt;

  result_t     res_a, res_b, rec;
  logic [1:0]  n;
  logic [3:0]  cnt;
  logic [31:0] acc_ins;

  always_comb begin
    header_nxt = header_r;
    lstart_nxt = lstart_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    bases_nxt  = bases_r;
    seqs_nxt   = seqs_r;
    res_a      = '0;
    res_b      = '0;
    rec        = '0;
    n          = 2'd0;
    cnt        = cnt_r;
    acc_ins    = '0;

    if (data_byte == ASCII_NL) begin
      lstart_nxt = 1'b1;
      header_nxt = 1'b0;
    end else if (lstart_r && data_byte == ASCII_GT) begin
      lstart_nxt = 1'b0;
      header_nxt = 1'b1;
      if (!end_of_data) begin
        rec         = '0;
        rec.rtype   = REC_START;
        rec.seq_idx = seqs_r;
        rec.pos     = bases_r + 32'd1;
        res_a       = rec;
        n           = 2'd1;
        if (seqs_r != 16'hFFFF) begin
          seqs_nxt = seqs_r + 16'd1;
        end
      end
    end else if (header_r) begin
      lstart_nxt = 1'b0;
    end else begin
      lstart_nxt = 1'b0;
      if (cnt_r >= 4'(WORD_CODES)) begin
        cnt = 4'd0;
      end
      acc_ins   = {28'd0, base_code(data_byte)} << (5'd28 - {cnt[2:0], 2'b00});
      acc_nxt   = acc_r | acc_ins;
      cnt_nxt   = cnt + 4'd1;
      bases_nxt = bases_r + 32'd1;
      if (cnt_nxt >= 4'(WORD_CODES)) begin
        rec        = '0;
        rec.rtype  = REC_WORD;
        rec.word   = acc_nxt;
        rec.nvalid = cnt_nxt;
        res_a      = rec;
        n          = 2'd1;
        acc_nxt    = '0;
        cnt_nxt    = 4'd0;
      end
    end

    if (end_of_data) begin
      if (cnt_nxt != 4'd0) begin
        rec        = '0;
        rec.rtype  = REC_WORD;
        rec.word   = acc_nxt;
        rec.nvalid = cnt_nxt;
        if (n == 2'd0) begin
          res_a = rec;
        end else begin
          res_b = rec;
        end
        n = n + 2'd1;
      end
      rec       = '0;
      rec.rtype = REC_END;
      rec.pos   = bases_nxt;
      if (n == 2'd0) begin
        res_a = rec;
      end else begin
        res_b = rec;
      end
      n = n + 2'd1;
      // back to the state of a fresh file
      header_nxt = 1'b0;
      lstart_nxt = 1'b1;
      acc_nxt    = '0;
      cnt_nxt    = 4'd0;
      bases_nxt  = '0;
      seqs_nxt   = '0;
    end

    res_a.last   = (n == 2'd1);
    res_b.last   = 1'b1;
    q_wdata.r0   = res_a;
    q_wdata.r1   = res_b;
    q_wdata.two  = (n == 2'd2);
    q_push       = take && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= 1'b0;
      lstart_r <= 1'b1;
      acc_r    <= '0;
      cnt_r    <= '0;
      bases_r  <= '0;
      seqs_r   <= '0;
    end else if (take) begin
      header_r <= header_nxt;
      lstart_r <= lstart_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      bases_r  <= bases_nxt;
      seqs_r   <= seqs_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/fnp_queue.sv */
`default_nettype none
module fnp_queue import fnp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pair_t wdata,
  input  wire logic  pop,
  output pair_t      rdata,
  output queue_stat_t stat
);

  pair_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/fnp_back.sv */
`default_nettype none
module fnp_back import fnp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire pair_t head,
  input  wire queue_stat_t stat,
  output logic       q_pop,
  input  wire logic  out_pop,
  output logic       out_valid,
  output result_t    out_res
);

  logic    valid_r, valid_nxt;
  logic    slot_r, slot_nxt;
  result_t res_r, res_nxt;
  logic    load;

  always_comb begin
    load      = !stat.empty && (!valid_r || out_pop);
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    if (load) begin
      res_nxt   = slot_r ? head.r1 : head.r0;
      valid_nxt = 1'b1;
      if (slot_r || !head.two) begin
        q_pop    = 1'b1;
        slot_nxt = 1'b0;
      end else begin
        slot_nxt = 1'b1;
      end
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/fasta_nucleotide_packer.sv */
`default_nettype none
// FASTA text in, packed 4-bit nucleotide codes out. One text byte enters per
// cycle through a push/full port. A '>' at the start of a line opens a header
// (text dropped) and yields a start record with the zero-based sequence index
// and the 1-based position of the next base. Sequence bytes (newline excluded)
// code A/C/G/T in either case as 0..3, anything else as 4, and pack eight to a
// 32-bit word, first base in bits 31:28; each full word is a type 0 record.
// A byte with end_of_data set flushes a partial word and then gives a type 2
// record with the total base count, after which the block starts a new file.
// Results leave through an empty/pop port, one per cycle while out_pop is
// held, last_result marking the final result of its input byte. A byte that
// produces two results holds the single output register for both in turn,
// so a run of such bytes drains at one result, not one byte, per cycle.
// Front end (classify and pack) and output stage are split by a 4-entry
// queue of per-byte result pairs; in_full rises only when that queue is
// full. A result is written to the queue, then to the output register.
module fasta_nucleotide_packer import fnp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_data,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic [1:0]       out_record_type,
  output logic [31:0]      out_packed_word,
  output logic [3:0]       out_codes_valid,
  output logic [15:0]      out_sequence_index,
  output logic [31:0]      out_base_position,
  output logic             out_last_result
);

`include "fasta_nucleotide_packer_assert.svh"

  queue_stat_t q_stat;
  pair_t       q_wdata, q_head;
  logic        q_push, q_pop;
  logic        take;
  logic        res_valid;
  result_t     res;

  // accepted byte on the input side
  assign take    = in_push && !q_stat.full;
  assign in_full = q_stat.full;

  fnp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_data_byte),
    .end_of_data (in_end_of_data),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  fnp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  fnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign out_empty          = !res_valid;
  assign out_record_type    = res.rtype;
  assign out_packed_word    = res.word;
  assign out_codes_valid    = res.nvalid;
  assign out_sequence_index = res.seq_idx;
  assign out_base_position  = res.pos;
  assign out_last_result    = res.last;

  // output register empties on reset
  `FNP_ASSERT_NEXT(a_reset_empty, !rst_n, out_empty, "output not empty after reset")
  // a word record carries between one and a full word of codes
  `FNP_ASSERT_IMP(a_word_count, !out_empty && res.rtype == REC_WORD,
    out_codes_valid != 4'd0 && out_codes_valid <= 4'(WORD_CODES), "bad codes_valid")
  // start and end records carry no codes
  `FNP_ASSERT_IMP(a_rec_nocodes, !out_empty && res.rtype != REC_WORD,
    out_packed_word == 32'd0 && out_codes_valid == 4'd0, "codes on non-word record")
  // an end record always closes its byte
  `FNP_ASSERT_IMP(a_end_last, !out_empty && res.rtype == REC_END,
    out_last_result, "end record not last")

endmodule
`default_nettype wire
